FILE: sv/xbr_pkg.sv
// shared types, protocol codes and the crc helper for the xmodem block receiver
package xbr_pkg;

  // protocol bytes
  localparam logic [7:0] SOH_CODE   = 8'h01;
  localparam logic [7:0] EOT_CODE   = 8'h04;
  localparam logic [7:0] ACK_CODE   = 8'h06;
  localparam logic [7:0] NAK_CODE   = 8'h15;
  localparam logic [7:0] INVITE_CRC = 8'h43;

  // crc-16 settings, msb first
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // tick limits outside the invitation phase
  localparam logic [8:0] PACKET_TICKS = 9'd2;
  localparam logic [8:0] NEXT_TICKS   = 9'd5;

  localparam int          DATA_BYTES_DEF   = 128;
  localparam logic [7:0]  INVITE_LIMIT_RST = 8'd10;
  localparam int          OFFSET_W         = 15;
  localparam int          CFG_IDX_W        = 1;
  localparam int          CFG_DATA_W       = 8;
  localparam int          OUT_TDATA_W      = 40;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVITE_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_START = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_INVITE,
    PH_NEXT,
    PH_NUM,
    PH_CNUM,
    PH_DATA,
    PH_CHK1,
    PH_CHK2
  } phase_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       check_mode;
    logic [7:0] invite_limit;
  } cfg_t;

  typedef struct packed {
    logic                session_over;
    logic                packet_good;
    logic                packet_done;
    logic [7:0]          write_byte;
    logic [OFFSET_W-1:0] write_offset;
    logic                write_valid;
    logic [7:0]          tx_byte;
    logic                tx_valid;
  } res_t;

  // one byte through the crc-16, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/xbr_core.sv
// session state machine, packet parser and check accumulators
module xbr_core #(
  parameter int DATA_BYTES = xbr_pkg::DATA_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_vld_i,
  input  xbr_pkg::item_t item_i,
  input  xbr_pkg::cfg_t  cfg_i,
  output logic          res_vld_o,
  output xbr_pkg::res_t  res_o
);

  localparam int IdxW = $clog2(DATA_BYTES + 1);
  localparam int OFFSET_W_L = xbr_pkg::OFFSET_W;

  xbr_pkg::phase_e phase_q, phase_d;
  logic [7:0]      block_q, block_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      chk_hi_q, chk_hi_d;
  logic [7:0]      tick_q, tick_d;
  logic            comp_ok_q, comp_ok_d;

  logic [7:0] b;
  logic       is_start, is_tick, is_byte, wait_ph, pkt_ph;
  logic [8:0] tick_inc, tick_lim;
  logic       tick_over;
  logic       ev_invite, ev_end_tick, ev_bad_tick;
  logic       ev_soh, ev_eot, ev_stray, ev_num, ev_cnum_ok, ev_cnum_bad;
  logic       ev_data, ev_chk1_sum, ev_chk1_hi, ev_chk2, ev_verdict, verdict_good;
  logic [OFFSET_W_L-1:0] blk_m1;
  logic [31:0]           off_full;
  logic [IdxW:0]         idx_inc;

  assign b        = item_i.rx_byte;
  assign wait_ph  = (phase_q == xbr_pkg::PH_INVITE) || (phase_q == xbr_pkg::PH_NEXT);
  assign pkt_ph   = !wait_ph && (phase_q != xbr_pkg::PH_IDLE);

  always_comb begin
    is_start = 1'b0;
    is_tick  = 1'b0;
    is_byte  = 1'b0;
    case (item_i.action)
      xbr_pkg::ACT_START: is_start = item_vld_i;
      xbr_pkg::ACT_TICK:  is_tick  = item_vld_i && (phase_q != xbr_pkg::PH_IDLE);
      xbr_pkg::ACT_BYTE:  is_byte  = item_vld_i && (phase_q != xbr_pkg::PH_IDLE);
      default: begin
      end
    endcase
  end

  assign tick_inc = {1'b0, tick_q} + 9'd1;

  always_comb begin
    case (phase_q)
      xbr_pkg::PH_INVITE: tick_lim = {1'b0, cfg_i.invite_limit};
      xbr_pkg::PH_NEXT:   tick_lim = xbr_pkg::NEXT_TICKS;
      default:            tick_lim = xbr_pkg::PACKET_TICKS;
    endcase
  end

  assign tick_over = tick_inc > tick_lim;

  // event decode shared by next-state and output logic
  assign ev_invite   = is_start || (is_tick && (phase_q == xbr_pkg::PH_INVITE) && !tick_over);
  assign ev_end_tick = is_tick && wait_ph && tick_over;
  assign ev_bad_tick = is_tick && pkt_ph && tick_over;
  assign ev_soh      = is_byte && wait_ph && (b == xbr_pkg::SOH_CODE);
  assign ev_eot      = is_byte && wait_ph && (b == xbr_pkg::EOT_CODE);
  assign ev_stray    = is_byte && wait_ph && (b != 8'h00) && (b != xbr_pkg::SOH_CODE)
                       && (b != xbr_pkg::EOT_CODE);
  assign ev_num      = is_byte && (phase_q == xbr_pkg::PH_NUM);
  assign ev_cnum_ok  = is_byte && (phase_q == xbr_pkg::PH_CNUM) && (b == ~block_q);
  assign ev_cnum_bad = is_byte && (phase_q == xbr_pkg::PH_CNUM) && (b != ~block_q);
  assign ev_data     = is_byte && (phase_q == xbr_pkg::PH_DATA);
  assign ev_chk1_sum = is_byte && (phase_q == xbr_pkg::PH_CHK1) && cfg_i.check_mode;
  assign ev_chk1_hi  = is_byte && (phase_q == xbr_pkg::PH_CHK1) && !cfg_i.check_mode;
  assign ev_chk2     = is_byte && (phase_q == xbr_pkg::PH_CHK2);
  assign ev_verdict  = ev_bad_tick || ev_cnum_bad || ev_chk1_sum || ev_chk2;

  always_comb begin
    verdict_good = 1'b0;
    if (ev_chk1_sum) begin
      verdict_good = comp_ok_q && (b == sum_q);
    end else if (ev_chk2) begin
      verdict_good = comp_ok_q && ({chk_hi_q, b} == crc_q);
    end
  end

  // image offset, block number minus one wraps in the offset width
  assign blk_m1   = {{(OFFSET_W_L-8){1'b0}}, block_q} - OFFSET_W_L'(1);
  assign off_full = 32'(blk_m1) * 32'(DATA_BYTES) + 32'(idx_q);
  assign idx_inc  = {1'b0, idx_q} + (IdxW+1)'(1);

  // next state
  always_comb begin
    phase_d   = phase_q;
    block_d   = block_q;
    idx_d     = idx_q;
    crc_d     = crc_q;
    sum_d     = sum_q;
    chk_hi_d  = chk_hi_q;
    tick_d    = tick_q;
    comp_ok_d = comp_ok_q;
    if (is_start) begin
      phase_d = xbr_pkg::PH_INVITE;
      tick_d  = '0;
    end else if (is_tick && !tick_over) begin
      tick_d = tick_inc[7:0];
    end else if (ev_end_tick || ev_eot || ev_stray) begin
      phase_d = xbr_pkg::PH_IDLE;
      tick_d  = '0;
    end else if (ev_soh) begin
      phase_d   = xbr_pkg::PH_NUM;
      tick_d    = '0;
      idx_d     = '0;
      crc_d     = xbr_pkg::CRC_INIT;
      sum_d     = '0;
      chk_hi_d  = '0;
      comp_ok_d = 1'b0;
    end else if (ev_num) begin
      block_d = b;
      phase_d = xbr_pkg::PH_CNUM;
      tick_d  = '0;
    end else if (ev_cnum_ok) begin
      comp_ok_d = 1'b1;
      phase_d   = xbr_pkg::PH_DATA;
      tick_d    = '0;
      idx_d     = '0;
    end else if (ev_data) begin
      crc_d = xbr_pkg::crc_byte(crc_q, b);
      sum_d = sum_q + b;
      idx_d = idx_inc[IdxW-1:0];
      if (idx_inc >= (IdxW+1)'(DATA_BYTES)) begin
        phase_d = xbr_pkg::PH_CHK1;
      end
    end else if (ev_chk1_hi) begin
      chk_hi_d = b;
      phase_d  = xbr_pkg::PH_CHK2;
    end
    if (ev_verdict) begin
      phase_d = xbr_pkg::PH_NEXT;
      tick_d  = '0;
      if (ev_cnum_bad) begin
        comp_ok_d = 1'b0;
      end
    end
  end

  // result
  always_comb begin
    res_o     = '0;
    res_vld_o = ev_invite || ev_end_tick || ev_eot || ev_stray || ev_data || ev_verdict;
    if (ev_invite) begin
      res_o.tx_valid = 1'b1;
      res_o.tx_byte  = cfg_i.check_mode ? xbr_pkg::NAK_CODE : xbr_pkg::INVITE_CRC;
    end
    if (ev_eot) begin
      res_o.tx_valid = 1'b1;
      res_o.tx_byte  = xbr_pkg::ACK_CODE;
    end
    if (ev_end_tick || ev_eot || ev_stray) begin
      res_o.session_over = 1'b1;
    end
    if (ev_data) begin
      res_o.write_valid  = 1'b1;
      res_o.write_offset = off_full[OFFSET_W_L-1:0];
      res_o.write_byte   = b;
    end
    if (ev_verdict) begin
      res_o.tx_valid    = 1'b1;
      res_o.tx_byte     = verdict_good ? xbr_pkg::ACK_CODE : xbr_pkg::NAK_CODE;
      res_o.packet_done = 1'b1;
      res_o.packet_good = verdict_good;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= xbr_pkg::PH_IDLE;
      block_q   <= '0;
      idx_q     <= '0;
      crc_q     <= '0;
      sum_q     <= '0;
      chk_hi_q  <= '0;
      tick_q    <= '0;
      comp_ok_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      block_q   <= block_d;
      idx_q     <= idx_d;
      crc_q     <= crc_d;
      sum_q     <= sum_d;
      chk_hi_q  <= chk_hi_d;
      tick_q    <= tick_d;
      comp_ok_q <= comp_ok_d;
    end
  end

endmodule

FILE: sv/xbr_obuf.sv
// two-entry result buffer between the core and the output stream
module xbr_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xbr_pkg::res_t  push_data_i,
  output logic          room_o,
  output logic          pop_vld_o,
  input  logic          pop_rdy_i,
  output xbr_pkg::res_t  pop_data_o
);

  xbr_pkg::res_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          pop;

  assign room_o     = (cnt_q != 2'd2);
  assign pop_vld_o  = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign pop        = pop_vld_o && pop_rdy_i;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: sv/xmodem_block_receiver_top.sv
// xmodem block receiver: events in, replies, payload writes and verdicts out
// each input transfer is one event: a received byte, a timeout tick or a session start
// (selected by s_axis_tuser). the block takes one event per clock cycle while the output
// buffer has room: an event lands in the input register, is decoded by the core (state
// update, byte-parallel crc-16 and the offset multiply-add) once the buffer has room, and
// its result, if any, is written into a two-entry output buffer at the end of that cycle,
// from which it is offered on the output stream. the buffer lets input keep flowing while
// a result waits on m_axis_tready; input stalls only once both buffer entries are full.
// events that cause no result (idle bytes, zero fill bytes, ticks under the limit outside
// the invitation phase, header bytes other than a bad block-number complement, crc-high
// bytes) produce no output transfer. configuration (check mode, invitation tick limit) is
// written through the cfg port and must only change while the block is idle.
module xmodem_block_receiver_top #(
  parameter int DATA_BYTES = xbr_pkg::DATA_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]                        s_axis_tuser,   // [1:0] action
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] write_valid, [24:10] write_offset,
  // [32:25] write_byte, [33] packet_done, [34] packet_good, [39:35] zero
  output logic [xbr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,   // session_over
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [xbr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [xbr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // input register
  logic           in_vld_q;
  xbr_pkg::item_t in_q;
  logic           advance;

  // configuration registers
  xbr_pkg::cfg_t  cfg_q;

  // core to buffer
  logic           res_vld;
  xbr_pkg::res_t  res;
  logic           room;
  xbr_pkg::res_t  out_res;

  // input register refills whenever it is empty or its event moves on this cycle
  assign s_axis_tready = !in_vld_q || room;
  assign advance       = in_vld_q && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.action  <= xbr_pkg::action_e'(s_axis_tuser);
      in_q.rx_byte <= s_axis_tdata;
    end
  end

  // configuration, to be written by the user only while idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_mode   <= 1'b0;
      cfg_q.invite_limit <= xbr_pkg::INVITE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        xbr_pkg::CFG_CHECK_MODE:   cfg_q.check_mode   <= cfg_data_i[0];
        xbr_pkg::CFG_INVITE_LIMIT: cfg_q.invite_limit <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  xbr_core #(
    .DATA_BYTES (DATA_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (advance),
    .item_i     (in_q),
    .cfg_i      (cfg_q),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  xbr_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance && res_vld),
    .push_data_i (res),
    .room_o      (room),
    .pop_vld_o   (m_axis_tvalid),
    .pop_rdy_i   (m_axis_tready),
    .pop_data_o  (out_res)
  );

  // pack the result, first field in the low bits
  assign m_axis_tdata = {5'b00000, out_res.packet_good, out_res.packet_done,
                         out_res.write_byte, out_res.write_offset, out_res.write_valid,
                         out_res.tx_byte, out_res.tx_valid};
  assign m_axis_tlast = out_res.session_over;

endmodule

FILE: sv/xbr_checker.sv
// port-level checks on the result stream of the xmodem block receiver
module xbr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [xbr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  logic       tx_valid, write_valid, packet_done, packet_good;
  logic [7:0] tx_byte;

  assign tx_valid    = m_axis_tdata[0];
  assign tx_byte     = m_axis_tdata[8:1];
  assign write_valid = m_axis_tdata[9];
  assign packet_done = m_axis_tdata[33];
  assign packet_good = m_axis_tdata[34];

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // only the three protocol replies are ever sent
  a_tx_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && tx_valid |-> (tx_byte == xbr_pkg::INVITE_CRC)
      || (tx_byte == xbr_pkg::NAK_CODE) || (tx_byte == xbr_pkg::ACK_CODE))
    else $error("unknown reply byte");

  // a verdict always carries its matching reply
  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && packet_done |-> tx_valid && !write_valid && !m_axis_tlast
      && (tx_byte == (packet_good ? xbr_pkg::ACK_CODE : xbr_pkg::NAK_CODE)))
    else $error("verdict without matching reply");

  // a payload write carries nothing else
  a_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && write_valid |-> !tx_valid && !packet_done && !m_axis_tlast)
    else $error("payload write mixed with other fields");

  // session end replies only with ack after eot
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && tx_valid |-> tx_byte == xbr_pkg::ACK_CODE)
    else $error("session end with wrong reply");

endmodule

bind xmodem_block_receiver_top xbr_checker u_xbr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
